>>> hdl/nm64_pkg.sv
package nm64_pkg;

    localparam int LOG2_WIDTH_DEF = 6;
    localparam int MAX_LVL        = 6;
    localparam int MAX_HALF       = 1 << (MAX_LVL - 1);

    // per level: row i of the map x -> x (nim*) 2^(h-1) over an h-bit subfield
    typedef logic [MAX_LVL:1][MAX_HALF-1:0][MAX_HALF-1:0] t_rows;

    function automatic int pow3(input int e);
        int r;
        r = 1;
        for (int i = 0; i < e; i++) begin
            r = r * 3;
        end
        return r;
    endfunction

    // nim product within the field of 2^lvl bits
    function automatic logic [63:0] nim_mul(input logic [63:0] a, input logic [63:0] b,
                                            input int lvl);
        logic [63:0] msk;
        logic [63:0] ah;
        logic [63:0] al;
        logic [63:0] bh;
        logic [63:0] bl;
        logic [63:0] hh;
        logic [63:0] ll;
        logic [63:0] pp;
        logic [63:0] lo;
        int          h;
        if (lvl == 0) begin
            return {63'd0, a[0] & b[0]};
        end
        h   = 1 << (lvl - 1);
        msk = (64'd1 << h) - 64'd1;
        ah  = (a >> h) & msk;
        al  = a & msk;
        bh  = (b >> h) & msk;
        bl  = b & msk;
        hh  = nim_mul(ah, bh, lvl - 1);
        ll  = nim_mul(al, bl, lvl - 1);
        pp  = nim_mul(ah ^ al, bh ^ bl, lvl - 1);
        lo  = ll ^ nim_mul(hh, 64'd1 << (h - 1), lvl - 1);
        return (((pp ^ ll) & msk) << h) | (lo & msk);
    endfunction

    function automatic t_rows half_rows();
        t_rows       rows;
        logic [63:0] col;
        int          h;
        rows = '0;
        for (int l = 1; l <= MAX_LVL; l++) begin
            h = 1 << (l - 1);
            for (int j = 0; j < h; j++) begin
                col = nim_mul(64'd1 << j, 64'd1 << (h - 1), l - 1);
                for (int i = 0; i < h; i++) begin
                    rows[l][i][j] = col[i];
                end
            end
        end
        return rows;
    endfunction

endpackage

>>> hdl/nimber_multiply_64.sv
// Pipelined nim multiplier. A pair of factors is taken in every cycle in which start is
// high (busy is always low). Its nim product is on o_product with o_valid high for one
// cycle, once it has passed through the register stages described below,
// and is taken at the edge that ends that cycle; there is no backpressure, so the
// receiver must take each product when it is strobed. The factors are registered first,
// one register stage then forms all 3^LOG2_WIDTH single-bit Karatsuba leaf products, and
// one stage per recursion level folds three half-width products into one, the last of
// which drives o_product. Factor bits above 2^LOG2_WIDTH - 1 are ignored and the product
// is zero-extended to 64 bits.
module nimber_multiply_64 #(
    parameter int LOG2_WIDTH = nm64_pkg::LOG2_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_operand_x,
    input  logic [63:0] i_operand_y,
    output logic        o_valid,
    output logic [63:0] o_product
);

    localparam int L    = LOG2_WIDTH;
    localparam int W    = 1 << L;
    localparam int LEAF = nm64_pkg::pow3(L);
    localparam nm64_pkg::t_rows ROWS = nm64_pkg::half_rows();

    logic [W-1:0]             r_x;
    logic [W-1:0]             r_y;
    logic                     r_in_vld;
    logic [L:0][LEAF-1:0]     exp_a;
    logic [L:0][LEAF-1:0]     exp_b;
    logic [L:0][LEAF-1:0]     n_lvl;
    logic [L:0][LEAF-1:0]     r_lvl;
    logic [L:0]               r_vld;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        r_x   <= i_operand_x[W-1:0];
        r_y   <= i_operand_y[W-1:0];
        r_lvl <= n_lvl;
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_vld    <= '0;
        end else begin
            r_in_vld <= start;
            r_vld    <= {r_vld[L-1:0], r_in_vld};
        end
    end

    // zero fill of the unused upper bits at each level
    genvar gl, gn, gi;
    generate
        for (gl = 0; gl <= L; gl++) begin : g_fill
            localparam int USED = nm64_pkg::pow3(L - gl) * (1 << gl);
            if (USED < LEAF) begin : g_pad
                assign exp_a[gl][LEAF-1:USED] = '0;
                assign exp_b[gl][LEAF-1:USED] = '0;
                assign n_lvl[gl][LEAF-1:USED] = '0;
            end
        end
    endgenerate

    // operand expansion: children high, low, high^low of each node
    assign exp_a[L][W-1:0] = r_x;
    assign exp_b[L][W-1:0] = r_y;

    generate
        for (gl = L; gl >= 1; gl--) begin : g_exp
            localparam int WL = 1 << gl;
            localparam int H  = WL / 2;
            for (gn = 0; gn < nm64_pkg::pow3(L - gl); gn++) begin : g_node
                logic [WL-1:0] pa;
                logic [WL-1:0] pb;
                assign pa = exp_a[gl][gn*WL +: WL];
                assign pb = exp_b[gl][gn*WL +: WL];
                assign exp_a[gl-1][(3*gn)*H +: H]   = pa[WL-1:H];
                assign exp_a[gl-1][(3*gn+1)*H +: H] = pa[H-1:0];
                assign exp_a[gl-1][(3*gn+2)*H +: H] = pa[WL-1:H] ^ pa[H-1:0];
                assign exp_b[gl-1][(3*gn)*H +: H]   = pb[WL-1:H];
                assign exp_b[gl-1][(3*gn+1)*H +: H] = pb[H-1:0];
                assign exp_b[gl-1][(3*gn+2)*H +: H] = pb[WL-1:H] ^ pb[H-1:0];
            end
        end
    endgenerate

    assign n_lvl[0] = exp_a[0] & exp_b[0];

    // fold: high = pp ^ ll, low = ll ^ hh * 2^(h-1)
    generate
        for (gl = 1; gl <= L; gl++) begin : g_fold
            localparam int WL = 1 << gl;
            localparam int H  = WL / 2;
            for (gn = 0; gn < nm64_pkg::pow3(L - gl); gn++) begin : g_node
                logic [H-1:0] hh;
                logic [H-1:0] ll;
                logic [H-1:0] pp;
                assign hh = r_lvl[gl-1][(3*gn)*H +: H];
                assign ll = r_lvl[gl-1][(3*gn+1)*H +: H];
                assign pp = r_lvl[gl-1][(3*gn+2)*H +: H];
                assign n_lvl[gl][gn*WL+H +: H] = pp ^ ll;
                for (gi = 0; gi < H; gi++) begin : g_bit
                    assign n_lvl[gl][gn*WL+gi] = ll[gi] ^ (^(hh & ROWS[gl][gi][H-1:0]));
                end
            end
        end
    endgenerate

    assign o_valid   = r_vld[L];
    assign o_product = 64'(r_lvl[L][W-1:0]);

endmodule
